// File: design/ncs_pkg.sv
// ----------------------------------------------------------------------------
// ncs_pkg: shared types and constants
// Pixel and cost widths, register indexes and the front-to-back item.
// ----------------------------------------------------------------------------
package ncs_pkg;

  localparam int MAX_COLUMNS_DEF    = 1024;
  localparam int PIXEL_BITS         = 8;
  localparam int COST_FRACTION_BITS = 14;
  localparam int COST_W             = 16;
  localparam int CFG_W              = 11;
  localparam int ROW_LIMIT          = 1024;
  localparam int ROW_W              = $clog2(ROW_LIMIT);
  localparam int MIN_SIZE           = 3;
  localparam int QUEUE_DEPTH        = 4;

  // register indexes
  localparam logic REG_COLUMNS = 1'b0;
  localparam logic REG_ROWS    = 1'b1;

  // arithmetic widths
  localparam int SW   = PIXEL_BITS + 4;       // nine-sample sum
  localparam int SQW  = 2 * PIXEL_BITS + 4;   // nine-sample sum of products
  localparam int VW   = 2 * PIXEL_BITS + 7;   // 9*Sxx - Sx*Sx
  localparam int CVW  = VW + 1;               // signed covariance
  localparam int PW   = 2 * VW;               // Vb*Vm
  localparam int TW   = COST_FRACTION_BITS + 1;
  localparam int OSW  = 2 * (TW + 1);         // (2t-1)^2
  localparam int RHW  = PW + 2 * COST_FRACTION_BITS + 2;
  localparam int PRW  = OSW + PW;

  typedef logic [PIXEL_BITS-1:0] pix_t;

  typedef struct packed {
    pix_t [8:0] b;       // 3x3 base window, index row*3+col
    pix_t [8:0] m;       // 3x3 match window
    logic       row_last;
    logic       frame_last;
  } item_t;

  typedef struct packed {
    pix_t b_top;
    pix_t b_mid;
    pix_t m_top;
    pix_t m_mid;
  } line_t;

endpackage

// File: design/ncs_front.sv
// ----------------------------------------------------------------------------
// ncs_front: raster tracking, line stores and 3x3 windows
// Accepts one pixel pair per cycle while room is set, pushes a window for every full position.
// ----------------------------------------------------------------------------
module ncs_front #(
  parameter int MAX_COLUMNS = ncs_pkg::MAX_COLUMNS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [ncs_pkg::CFG_W-1:0]  cfg_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  ncs_pkg::pix_t              in_b,
  input  ncs_pkg::pix_t              in_m,
  input  logic                       room,
  output logic                       push,
  output ncs_pkg::item_t             push_item
);

  localparam int CW     = $clog2(MAX_COLUMNS);
  localparam int COLS_W = $clog2(MAX_COLUMNS + 1);
  localparam int RW     = ncs_pkg::ROW_W;

  logic [ncs_pkg::CFG_W-1:0] padded_columns, padded_rows;
  logic [COLS_W-1:0]         cols_eff, col_inc;
  logic [ncs_pkg::CFG_W-1:0] rows_eff;
  logic [CW-1:0]             col, c_eff;
  logic [RW-1:0]             row, r_eff;
  logic                      accept, emit, rl, fl;

  // stage 1 registers
  logic          s1_valid, s1_emit, s1_rl, s1_fl;
  logic [CW-1:0] s1_addr;
  ncs_pkg::pix_t s1_b, s1_m;
  ncs_pkg::line_t rd, wr;
  ncs_pkg::line_t store [MAX_COLUMNS];

  ncs_pkg::pix_t [8:0] win_b, win_m, win_b_next, win_m_next;

  assign in_ready = room;
  assign accept   = in_valid && room;

  always_comb begin
    if (padded_columns < ncs_pkg::CFG_W'(ncs_pkg::MIN_SIZE)) begin
      cols_eff = COLS_W'(ncs_pkg::MIN_SIZE);
    end else if (32'(padded_columns) > 32'(MAX_COLUMNS)) begin
      cols_eff = COLS_W'(MAX_COLUMNS);
    end else begin
      cols_eff = COLS_W'(padded_columns);
    end
    if (padded_rows < ncs_pkg::CFG_W'(ncs_pkg::MIN_SIZE)) begin
      rows_eff = ncs_pkg::CFG_W'(ncs_pkg::MIN_SIZE);
    end else if (padded_rows > ncs_pkg::CFG_W'(ncs_pkg::ROW_LIMIT)) begin
      rows_eff = ncs_pkg::CFG_W'(ncs_pkg::ROW_LIMIT);
    end else begin
      rows_eff = padded_rows;
    end
    c_eff   = (COLS_W'(col) >= cols_eff) ? '0 : col;
    r_eff   = (ncs_pkg::CFG_W'(row) >= rows_eff) ? '0 : row;
    col_inc = COLS_W'(c_eff) + COLS_W'(1);
    emit    = (r_eff >= RW'(2)) && (c_eff >= CW'(2));
    rl      = (COLS_W'(c_eff) == cols_eff - COLS_W'(1));
    fl      = rl && (ncs_pkg::CFG_W'(r_eff) == rows_eff - ncs_pkg::CFG_W'(1));
  end

  // config and raster position
  always_ff @(posedge clk) begin
    if (rst) begin
      padded_columns <= ncs_pkg::CFG_W'(1024);
      padded_rows    <= ncs_pkg::CFG_W'(1024);
      col            <= '0;
      row            <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        ncs_pkg::REG_COLUMNS: padded_columns <= cfg_data;
        ncs_pkg::REG_ROWS:    padded_rows    <= cfg_data;
        default:              padded_rows    <= padded_rows;
      endcase
      col <= '0;
      row <= '0;
    end else if (accept) begin
      if (col_inc >= cols_eff) begin
        col <= '0;
        if (ncs_pkg::CFG_W'(r_eff) + ncs_pkg::CFG_W'(1) >= rows_eff) begin
          row <= '0;
        end else begin
          row <= r_eff + RW'(1);
        end
      end else begin
        col <= CW'(col_inc);
        row <= r_eff;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_emit <= emit;
      s1_rl   <= rl;
      s1_fl   <= fl;
      s1_addr <= c_eff;
      s1_b    <= in_b;
      s1_m    <= in_m;
    end
  end

  // line store: read on accept, rotate and write back in the following cycle
  assign wr = '{b_top: rd.b_mid, b_mid: s1_b, m_top: rd.m_mid, m_mid: s1_m};

  always_ff @(posedge clk) begin
    if (accept) begin
      rd <= store[c_eff];
    end
    if (s1_valid) begin
      store[s1_addr] <= wr;
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_b_next[r*3]   = win_b[r*3+1];
      win_b_next[r*3+1] = win_b[r*3+2];
      win_m_next[r*3]   = win_m[r*3+1];
      win_m_next[r*3+1] = win_m[r*3+2];
    end
    win_b_next[2] = rd.b_top;
    win_b_next[5] = rd.b_mid;
    win_b_next[8] = s1_b;
    win_m_next[2] = rd.m_top;
    win_m_next[5] = rd.m_mid;
    win_m_next[8] = s1_m;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win_b <= '0;
      win_m <= '0;
    end else if (s1_valid) begin
      win_b <= win_b_next;
      win_m <= win_m_next;
    end
  end

  assign push      = s1_valid && s1_emit;
  assign push_item = '{b: win_b_next, m: win_m_next, row_last: s1_rl, frame_last: s1_fl};

endmodule

// File: design/ncs_queue.sv
// ----------------------------------------------------------------------------
// ncs_queue: window queue between front and cost unit
// Small register FIFO; room means at least two free slots.
// ----------------------------------------------------------------------------
module ncs_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  ncs_pkg::item_t  push_item,
  output logic            room,
  output logic            head_valid,
  output ncs_pkg::item_t  head_item,
  input  logic            pop
);

  localparam int AW = $clog2(ncs_pkg::QUEUE_DEPTH);

  ncs_pkg::item_t  slots [ncs_pkg::QUEUE_DEPTH];
  logic [AW-1:0]   wp, rp;
  logic [AW:0]     count;
  logic            do_pop;

  assign head_valid = (count != '0);
  assign head_item  = slots[rp];
  assign room       = (count <= (AW+1)'(ncs_pkg::QUEUE_DEPTH - 2));
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wp <= wp + AW'(1);
      end
      if (do_pop) begin
        rp <= rp + AW'(1);
      end
      count <= count + (AW+1)'(push) - (AW+1)'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wp] <= push_item;
    end
  end

endmodule

// File: design/ncs_back.sv
// ----------------------------------------------------------------------------
// ncs_back: correlation cost unit
// Sums the window serially, forms variances, then rounds the cost by a
// bit-by-bit search on (2t-1)^2 * Vb*Vm <= 4*C^2*2^(2F); a flat window skips the search.
// ----------------------------------------------------------------------------
module ncs_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        head_valid,
  input  ncs_pkg::item_t              head_item,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [ncs_pkg::COST_W-1:0]  out_cost,
  output logic                        out_row_last,
  output logic                        out_frame_last
);

  localparam int F   = ncs_pkg::COST_FRACTION_BITS;
  localparam int TW  = ncs_pkg::TW;
  localparam int VW  = ncs_pkg::VW;
  localparam int PW  = ncs_pkg::PW;
  localparam int HW  = PW / 2;
  localparam int OSW = ncs_pkg::OSW;
  localparam int PRW = ncs_pkg::PRW;
  localparam int BPW = $clog2(TW);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_SUM  = 9'b000000010,
    S_VAR  = 9'b000000100,
    S_PROD = 9'b000001000,
    S_SQ   = 9'b000010000,
    S_MLO  = 9'b000100000,
    S_MHI  = 9'b001000000,
    S_CMP  = 9'b010000000,
    S_DONE = 9'b100000000
  } state_t;

  state_t                    state;
  ncs_pkg::item_t            item;
  logic [3:0]                idx;
  logic [ncs_pkg::SW-1:0]    sb, sm;
  logic [ncs_pkg::SQW-1:0]   sbb, smm, sbm;
  logic [VW-1:0]             vb, vm, mag;
  logic signed [ncs_pkg::CVW-1:0] cov;
  logic                      neg;
  logic [PW-1:0]             p;
  logic [ncs_pkg::RHW-1:0]   rhs;
  logic [TW-1:0]             ans, trial, one, trial_next;
  logic [BPW-1:0]            bit_pos;
  logic [OSW-1:0]            osq;
  logic [OSW+HW-1:0]         plo, phi;
  logic [PRW-1:0]            total;
  logic [TW:0]               odd;
  logic [31:0]               res;
  ncs_pkg::pix_t             pb, pm;

  assign one        = TW'(1) << F;
  assign pb         = item.b[idx];
  assign pm         = item.m[idx];
  assign mag        = cov[ncs_pkg::CVW-1] ? VW'(-cov) : VW'(cov);
  assign trial_next = ans | (TW'(1) << bit_pos);
  assign odd        = {trial_next, 1'b0} - (TW+1)'(1);
  assign total      = (PRW'(phi) << HW) + PRW'(plo);
  assign res        = neg ? 32'(one) + 32'(ans) : 32'(one) - 32'(ans);
  assign pop        = (state == S_IDLE) && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (head_valid) begin
            state <= S_SUM;
          end
        end
        S_SUM: begin
          if (idx == 4'd8) begin
            state <= S_VAR;
          end
        end
        S_VAR:  state <= S_PROD;
        S_PROD: state <= (vb == '0 || vm == '0) ? S_DONE : S_SQ;
        S_SQ: begin
          if (trial_next > one) begin
            if (bit_pos == '0) begin
              state <= S_DONE;
            end
          end else begin
            state <= S_MLO;
          end
        end
        S_MLO:  state <= S_MHI;
        S_MHI:  state <= S_CMP;
        S_CMP:  state <= (bit_pos == '0) ? S_DONE : S_SQ;
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        item <= head_item;
        idx  <= '0;
        sb   <= '0;
        sm   <= '0;
        sbb  <= '0;
        smm  <= '0;
        sbm  <= '0;
      end
      S_SUM: begin
        idx <= idx + 4'd1;
        sb  <= sb + ncs_pkg::SW'(pb);
        sm  <= sm + ncs_pkg::SW'(pm);
        sbb <= sbb + ncs_pkg::SQW'(pb) * ncs_pkg::SQW'(pb);
        smm <= smm + ncs_pkg::SQW'(pm) * ncs_pkg::SQW'(pm);
        sbm <= sbm + ncs_pkg::SQW'(pb) * ncs_pkg::SQW'(pm);
      end
      S_VAR: begin
        vb  <= VW'(sbb) * VW'(9) - VW'(sb) * VW'(sb);
        vm  <= VW'(smm) * VW'(9) - VW'(sm) * VW'(sm);
        cov <= ncs_pkg::CVW'(sbm) * ncs_pkg::CVW'(9) - ncs_pkg::CVW'(sb) * ncs_pkg::CVW'(sm);
      end
      S_PROD: begin
        // flat window: covariance is zero, cost is 1.0
        p       <= PW'(vb) * PW'(vm);
        rhs     <= {PW'(mag) * PW'(mag), (2 * F + 2)'(0)};
        neg     <= (vb != '0) && (vm != '0) && cov[ncs_pkg::CVW-1];
        ans     <= '0;
        bit_pos <= BPW'(F);
      end
      S_SQ: begin
        trial <= trial_next;
        osq   <= OSW'(odd) * OSW'(odd);
        if (trial_next > one && bit_pos != '0) begin
          bit_pos <= bit_pos - BPW'(1);
        end
      end
      S_MLO: plo <= (OSW+HW)'(osq) * (OSW+HW)'(p[HW-1:0]);
      S_MHI: phi <= (OSW+HW)'(osq) * (OSW+HW)'(p[PW-1:HW]);
      S_CMP: begin
        if (total <= PRW'(rhs)) begin
          ans <= trial;
        end
        if (bit_pos != '0) begin
          bit_pos <= bit_pos - BPW'(1);
        end
      end
      S_DONE: begin
        // hold the waiting cost until the output register frees up
        if (!out_valid || out_ready) begin
          out_cost       <= (res > 32'h0000FFFF) ? ncs_pkg::COST_W'(16'hFFFF)
                                                  : res[ncs_pkg::COST_W-1:0];
          out_row_last   <= item.row_last;
          out_frame_last <= item.frame_last;
        end
      end
      default: idx <= idx;
    endcase
  end

endmodule

// File: design/ncc_stereo_cost_3x3.sv
// ----------------------------------------------------------------------------
// ncc_stereo_cost_3x3: 3x3 zero-mean NCC stereo matching cost
// Front tracks the padded raster and builds windows, a short queue feeds a
// serial cost unit that emits 2^14 * (1 - rho).
// ----------------------------------------------------------------------------
// Path: the request that completes a window passes 1 front stage, the queue
//   write and the pop, then summing of the nine samples, the variance and
//   product setup, then 15 search steps; a flat window skips the search.
// Throughput: pixel pairs without a cost are taken one per cycle while the
//   queue has room; the cost unit takes a new window only once the last cost
//   is in the output register, and its search loop shares one odd-square and two partial-product multipliers.
// Reset: synchronous, clears position, windows, queue and output; registers
//   return to 1024; line store contents are undefined until written.
module ncc_stereo_cost_3x3 #(
  parameter int MAX_COLUMNS = ncs_pkg::MAX_COLUMNS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  // configuration writes: index 0 padded_columns, index 1 padded_rows
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [ncs_pkg::CFG_W-1:0]  cfg_data,
  // pixel pair requests
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [15:0]                s_axis_tdata,   // [7:0] base_pixel, [15:8] match_pixel
  // cost requests
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [15:0]                m_axis_tdata,   // [15:0] cost
  output logic                       m_axis_tlast,   // row_last
  output logic [0:0]                 m_axis_tuser    // [0] frame_last
);

  logic            room, push, head_valid, pop;
  ncs_pkg::item_t  push_item, head_item;

  ncs_front #(.MAX_COLUMNS(MAX_COLUMNS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_b      (s_axis_tdata[7:0]),
    .in_m      (s_axis_tdata[15:8]),
    .room      (room),
    .push      (push),
    .push_item (push_item)
  );

  // windows wait here so the front keeps streaming while the cost unit works
  ncs_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .room       (room),
    .head_valid (head_valid),
    .head_item  (head_item),
    .pop        (pop)
  );

  ncs_back u_back (
    .clk            (clk),
    .rst            (rst),
    .head_valid     (head_valid),
    .head_item      (head_item),
    .pop            (pop),
    .out_valid      (m_axis_tvalid),
    .out_ready      (m_axis_tready),
    .out_cost       (m_axis_tdata),
    .out_row_last   (m_axis_tlast),
    .out_frame_last (m_axis_tuser[0])
  );

endmodule
